>>> src/mssd_pkg.sv
// Shared types, codes and helpers of the multiple string structure decoder.
// No dependencies; used by every module of the block.
package mssd_pkg;

	localparam int EV_FIFO_DEPTH = 8;
	localparam int MAX_EVENTS = 3;

	localparam logic [7:0] MODE_WIDE = 8'h3F;

	typedef enum logic [7:0] {
		PH_COUNT    = 8'b0000_0001,
		PH_LANG     = 8'b0000_0010,
		PH_SEGCOUNT = 8'b0000_0100,
		PH_COMP     = 8'b0000_1000,
		PH_MODE     = 8'b0001_0000,
		PH_LEN      = 8'b0010_0000,
		PH_PAYLOAD  = 8'b0100_0000,
		PH_DONE     = 8'b1000_0000
	} phase_t;

	typedef enum logic [2:0] {
		KIND_LANG  = 3'd0,
		KIND_CHAR  = 3'd1,
		KIND_END   = 3'd2,
		KIND_DONE  = 3'd3,
		KIND_ERROR = 3'd4
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] char_value;
		logic [7:0]  string_number;
		logic        final_event;
	} ev_t;

	// up to three events produced by one byte, lowest index first
	typedef struct packed {
		ev_t [MAX_EVENTS-1:0] ev;
		logic [1:0]           count;
	} ev_bundle_t;

	function automatic logic one_byte_mode(input logic [7:0] m);
		return (m <= 8'h06) || (m >= 8'h09 && m <= 8'h10) ||
		       (m >= 8'h20 && m <= 8'h27) || (m >= 8'h30 && m <= 8'h33);
	endfunction

endpackage

>>> src/mssd_decode.sv
// Parser state and per-byte event generation.
// Depends on mssd_pkg.
module mssd_decode
	import mssd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  logic [7:0] byte_s1,
	input  logic       last_s1,
	output ev_bundle_t bundle
);

	phase_t     phase_q, phase_d;
	logic [7:0] strings_left_q, strings_left_d;
	logic [7:0] segments_left_q, segments_left_d;
	logic [1:0] header_pos_q, header_pos_d;
	logic [7:0] segment_mode_q, segment_mode_d;
	logic       segment_plain_q, segment_plain_d;
	logic [7:0] payload_left_q, payload_left_d;
	logic [7:0] high_hold_q, high_hold_d;
	logic       pair_half_q, pair_half_d;
	logic [7:0] string_cnt_q, string_cnt_d;

	always_comb begin
		logic [1:0] n;
		logic [1:0] hp_inc;
		logic       do_seg;
		logic       do_str;
		ev_t        blank;

		blank = '{kind: KIND_LANG, char_value: 16'h0000, string_number: 8'h00,
		          final_event: 1'b0};
		bundle.ev = {MAX_EVENTS{blank}};
		n = 2'd0;
		do_seg = 1'b0;
		do_str = 1'b0;
		hp_inc = header_pos_q + 2'd1;

		phase_d         = phase_q;
		strings_left_d  = strings_left_q;
		segments_left_d = segments_left_q;
		header_pos_d    = header_pos_q;
		segment_mode_d  = segment_mode_q;
		segment_plain_d = segment_plain_q;
		payload_left_d  = payload_left_q;
		high_hold_d     = high_hold_q;
		pair_half_d     = pair_half_q;
		string_cnt_d    = string_cnt_q;

		case (phase_q)
			PH_COUNT: begin
				strings_left_d = byte_s1;
				string_cnt_d = 8'h00;
				if (byte_s1 == 8'h00) begin
					bundle.ev[n] = '{kind: KIND_DONE, char_value: 16'h0000,
					                 string_number: 8'h00, final_event: 1'b0};
					n = n + 2'd1;
					phase_d = PH_DONE;
				end else begin
					header_pos_d = 2'd0;
					phase_d = PH_LANG;
				end
			end
			PH_LANG: begin
				bundle.ev[n] = '{kind: KIND_LANG, char_value: {8'h00, byte_s1},
				                 string_number: string_cnt_q, final_event: 1'b0};
				n = n + 2'd1;
				if (hp_inc == 2'd3) begin
					header_pos_d = 2'd0;
					phase_d = PH_SEGCOUNT;
				end else begin
					header_pos_d = hp_inc;
				end
			end
			PH_SEGCOUNT: begin
				segments_left_d = byte_s1;
				if (byte_s1 == 8'h00) begin
					do_str = 1'b1;
				end else begin
					phase_d = PH_COMP;
				end
			end
			PH_COMP: begin
				segment_plain_d = (byte_s1 == 8'h00);
				phase_d = PH_MODE;
			end
			PH_MODE: begin
				segment_mode_d = byte_s1;
				phase_d = PH_LEN;
			end
			PH_LEN: begin
				payload_left_d = byte_s1;
				pair_half_d = 1'b0;
				if (byte_s1 == 8'h00) begin
					do_seg = 1'b1;
				end else begin
					phase_d = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				if (segment_plain_q) begin
					if (one_byte_mode(segment_mode_q)) begin
						bundle.ev[n] = '{kind: KIND_CHAR,
						                 char_value: {segment_mode_q, byte_s1},
						                 string_number: string_cnt_q, final_event: 1'b0};
						n = n + 2'd1;
					end else if (segment_mode_q == MODE_WIDE) begin
						if (!pair_half_q) begin
							high_hold_d = byte_s1;
							pair_half_d = 1'b1;
						end else begin
							bundle.ev[n] = '{kind: KIND_CHAR,
							                 char_value: {high_hold_q, byte_s1},
							                 string_number: string_cnt_q,
							                 final_event: 1'b0};
							n = n + 2'd1;
							pair_half_d = 1'b0;
						end
					end
				end
				payload_left_d = payload_left_q - 8'd1;
				if (payload_left_d == 8'h00) begin
					do_seg = 1'b1;
				end
			end
			default: begin
			end
		endcase

		if (do_seg) begin
			segments_left_d = segments_left_d - 8'd1;
			if (segments_left_d == 8'h00) begin
				do_str = 1'b1;
			end else begin
				phase_d = PH_COMP;
			end
		end

		if (do_str) begin
			bundle.ev[n] = '{kind: KIND_END, char_value: 16'h0000,
			                 string_number: string_cnt_d, final_event: 1'b0};
			n = n + 2'd1;
			strings_left_d = strings_left_d - 8'd1;
			string_cnt_d = string_cnt_d + 8'd1;
			if (strings_left_d == 8'h00) begin
				bundle.ev[n] = '{kind: KIND_DONE, char_value: 16'h0000,
				                 string_number: string_cnt_d, final_event: 1'b0};
				n = n + 2'd1;
				phase_d = PH_DONE;
			end else begin
				header_pos_d = 2'd0;
				phase_d = PH_LANG;
			end
		end

		// last byte: report an error if the structure is unfinished, then start over on the next byte
		if (last_s1) begin
			if (phase_d != PH_DONE) begin
				bundle.ev[n] = '{kind: KIND_ERROR, char_value: 16'h0000,
				                 string_number: string_cnt_d, final_event: 1'b0};
				n = n + 2'd1;
			end
			phase_d         = PH_COUNT;
			strings_left_d  = 8'h00;
			segments_left_d = 8'h00;
			header_pos_d    = 2'd0;
			segment_mode_d  = 8'h00;
			segment_plain_d = 1'b0;
			payload_left_d  = 8'h00;
			high_hold_d     = 8'h00;
			pair_half_d     = 1'b0;
			string_cnt_d    = 8'h00;
		end

		if (n != 2'd0) begin
			bundle.ev[n - 2'd1].final_event = 1'b1;
		end
		bundle.count = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_COUNT;
			strings_left_q  <= 8'h00;
			segments_left_q <= 8'h00;
			header_pos_q    <= 2'd0;
			segment_mode_q  <= 8'h00;
			segment_plain_q <= 1'b0;
			payload_left_q  <= 8'h00;
			high_hold_q     <= 8'h00;
			pair_half_q     <= 1'b0;
			string_cnt_q    <= 8'h00;
		end else if (advance) begin
			phase_q         <= phase_d;
			strings_left_q  <= strings_left_d;
			segments_left_q <= segments_left_d;
			header_pos_q    <= header_pos_d;
			segment_mode_q  <= segment_mode_d;
			segment_plain_q <= segment_plain_d;
			payload_left_q  <= payload_left_d;
			high_hold_q     <= high_hold_d;
			pair_half_q     <= pair_half_d;
			string_cnt_q    <= string_cnt_d;
		end
	end

endmodule

>>> src/mssd_event_fifo.sv
// Result queue: takes up to three events at once, hands out one per cycle while ev_stall is low.
// Depends on mssd_pkg.
module mssd_event_fifo
	import mssd_pkg::*;
#(
	parameter int DEPTH = EV_FIFO_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  ev_bundle_t bundle,
	output logic       room,
	output logic       ev_valid,
	input  logic       ev_stall,
	output ev_t        ev_head
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	ev_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] wa [MAX_EVENTS+1];
	logic          pop;
	logic [CW-1:0] n_push;

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	always_comb begin
		wa[0] = wr_ptr_q;
		for (int i = 1; i <= MAX_EVENTS; i++) begin
			wa[i] = wrap_inc(wa[i-1]);
		end
	end

	assign room     = (CW'(DEPTH) - count_q) >= CW'(MAX_EVENTS);
	assign ev_valid = (count_q != '0);
	assign pop      = ev_valid && !ev_stall;
	assign n_push   = push ? CW'(bundle.count) : '0;
	assign ev_head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			for (int i = 0; i < MAX_EVENTS; i++) begin
				if (2'(i) < bundle.count) begin
					mem_q[wa[i]] <= bundle.ev[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wa[bundle.count];
			end
			if (pop) begin
				rd_ptr_q <= wrap_inc(rd_ptr_q);
			end
			count_q <= count_q + n_push - CW'(pop);
		end
	end

endmodule

>>> src/multiple_string_structure_decoder_core.sv
// Top level of the multiple string structure decoder.
// Depends on mssd_pkg, mssd_decode and mssd_event_fifo.
//
//   channel   handshake                   payload
//   byte      byte_valid / byte_stall     byte_value, last_byte
//   event     event_valid / event_stall   kind, char_value, string_number, final_event
//
// One byte is taken per cycle into the input register while byte_stall is low,
// and decoded from there; its zero to three events land in the result queue
// together. A byte waits in the input register while the queue has fewer than
// three free entries, so throughput is one byte per cycle as long as the event
// side keeps pace; each event leaves the queue in a cycle of its own. Reset
// clears the parser and the queue at once; no clearing pass is needed.
module multiple_string_structure_decoder_core
	import mssd_pkg::*;
#(
	parameter int FIFO_DEPTH = EV_FIFO_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  byte_value,
	input  logic        last_byte,
	output logic        event_valid,
	input  logic        event_stall,
	output logic [2:0]  kind,
	output logic [15:0] char_value,
	output logic [7:0]  string_number,
	output logic        final_event
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       room;
	logic       advance;
	ev_bundle_t bundle;
	ev_t        head;

	assign advance    = valid_s1 && room;
	assign byte_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	// hold the request while the queue is short of space
	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid) begin
			byte_s1 <= byte_value;
			last_s1 <= last_byte;
		end
	end

	mssd_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.byte_s1 (byte_s1),
		.last_s1 (last_s1),
		.bundle  (bundle)
	);

	mssd_event_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (advance),
		.bundle   (bundle),
		.room     (room),
		.ev_valid (event_valid),
		.ev_stall (event_stall),
		.ev_head  (head)
	);

	assign kind          = head.kind;
	assign char_value    = head.char_value;
	assign string_number = head.string_number;
	assign final_event   = head.final_event;

endmodule

>>> src/mssd_checker.sv
// Port-level checks of the decoder's event channel, bound to the top level.
// Depends on mssd_pkg and multiple_string_structure_decoder_core.
module mssd_checker
	import mssd_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        event_valid,
	input logic        event_stall,
	input logic [2:0]  kind,
	input logic [15:0] char_value,
	input logic [7:0]  string_number,
	input logic        final_event
);

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid |-> kind <= KIND_ERROR)
		else $error("event kind out of range");

	a_held: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid && event_stall |=> event_valid && $stable(kind) &&
			$stable(char_value) && $stable(string_number) && $stable(final_event))
		else $error("stalled event changed");

	a_terminal_final: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid && (kind == KIND_DONE || kind == KIND_ERROR) |-> final_event)
		else $error("done or error event not last of its byte");

	a_lang_byte: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid && kind == KIND_LANG |-> char_value[15:8] == 8'h00)
		else $error("language event wider than a byte");

	a_no_value: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid && (kind == KIND_END || kind == KIND_DONE || kind == KIND_ERROR)
			|-> char_value == 16'h0000)
		else $error("control event carries a value");

endmodule

bind multiple_string_structure_decoder_core mssd_checker u_mssd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.event_valid   (event_valid),
	.event_stall   (event_stall),
	.kind          (kind),
	.char_value    (char_value),
	.string_number (string_number),
	.final_event   (final_event)
);

>>> tb/multiple_string_structure_decoder_core_tb.sv
// Self-checking testbench for multiple_string_structure_decoder_core.
// Builds byte requests, predicts the decoder events and checks each event taken.
// Depends on mssd_pkg for the event record and the kind and phase codes.
module multiple_string_structure_decoder_core_tb
	import mssd_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_BYTES = 400;
	localparam int CYCLE_LIMIT = 100000;
	localparam int DRAIN_CYCLES = 20;

	typedef struct packed {
		logic [7:0] value;
		logic       is_last;
	} stim_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        byte_valid = 1'b0;
	logic        byte_stall;
	logic [7:0]  byte_value = 8'h00;
	logic        last_byte = 1'b0;
	logic        event_valid;
	logic        event_stall = 1'b0;
	logic [2:0]  kind;
	logic [15:0] char_value;
	logic [7:0]  string_number;
	logic        final_event;

	stim_byte_t byte_queue[$];
	ev_t        pending_events[$];
	stim_byte_t next_req;
	ev_t        want;
	logic       req_taken = 1'b0;
	int         bytes_taken = 0;
	int         total_bytes = 0;
	int         error_count = 0;
	int         cycle_count = 0;

	// decoder state as predicted
	phase_t      dec_phase;
	logic [7:0]  str_left;
	logic [7:0]  seg_left;
	logic [1:0]  lang_pos;
	logic [7:0]  seg_mode;
	logic        seg_plain;
	logic [7:0]  pay_left;
	logic [7:0]  hi_hold;
	logic        pair_half;
	logic [7:0]  str_idx;

	multiple_string_structure_decoder_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.byte_value   (byte_value),
		.last_byte    (last_byte),
		.event_valid  (event_valid),
		.event_stall  (event_stall),
		.kind         (kind),
		.char_value   (char_value),
		.string_number(string_number),
		.final_event  (final_event)
	);

	always #2 clk = ~clk;

	function automatic logic is_narrow_mode(input logic [7:0] m);
		case (m[7:4])
			4'h0: return (m[3:0] <= 4'h6) || (m[3:0] >= 4'h9);
			4'h1: return m[3:0] == 4'h0;
			4'h2: return m[3:0] <= 4'h7;
			4'h3: return m[3:0] <= 4'h3;
			default: return 1'b0;
		endcase
	endfunction

	task automatic clear_decoder();
		dec_phase = PH_COUNT;
		str_left = 8'h00;
		seg_left = 8'h00;
		lang_pos = 2'd0;
		seg_mode = 8'h00;
		seg_plain = 1'b0;
		pay_left = 8'h00;
		hi_hold = 8'h00;
		pair_half = 1'b0;
		str_idx = 8'h00;
	endtask

	task automatic add_event(input kind_t k, input logic [15:0] v, input logic [7:0] n);
		ev_t e;
		e.kind = k;
		e.char_value = v;
		e.string_number = n;
		e.final_event = 1'b0;
		pending_events.insert(pending_events.size(), e);
	endtask

	task automatic close_string();
		add_event(KIND_END, 16'h0000, str_idx);
		str_left = str_left - 8'd1;
		str_idx = str_idx + 8'd1;
		if (str_left == 8'h00) begin
			add_event(KIND_DONE, 16'h0000, str_idx);
			dec_phase = PH_DONE;
		end else begin
			lang_pos = 2'd0;
			dec_phase = PH_LANG;
		end
	endtask

	task automatic close_segment();
		seg_left = seg_left - 8'd1;
		if (seg_left == 8'h00)
			close_string();
		else
			dec_phase = PH_COMP;
	endtask

	task automatic decode_byte(input logic [7:0] b, input logic is_last);
		int n0;
		ev_t e;
		n0 = pending_events.size();
		case (dec_phase)
			PH_COUNT: begin
				str_left = b;
				str_idx = 8'h00;
				if (b == 8'h00) begin
					add_event(KIND_DONE, 16'h0000, 8'h00);
					dec_phase = PH_DONE;
				end else begin
					lang_pos = 2'd0;
					dec_phase = PH_LANG;
				end
			end
			PH_LANG: begin
				add_event(KIND_LANG, {8'h00, b}, str_idx);
				lang_pos = lang_pos + 2'd1;
				if (lang_pos == 2'd3) begin
					lang_pos = 2'd0;
					dec_phase = PH_SEGCOUNT;
				end
			end
			PH_SEGCOUNT: begin
				seg_left = b;
				if (b == 8'h00)
					close_string();
				else
					dec_phase = PH_COMP;
			end
			PH_COMP: begin
				seg_plain = (b == 8'h00);
				dec_phase = PH_MODE;
			end
			PH_MODE: begin
				seg_mode = b;
				dec_phase = PH_LEN;
			end
			PH_LEN: begin
				pay_left = b;
				pair_half = 1'b0;
				if (b == 8'h00)
					close_segment();
				else
					dec_phase = PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				if (seg_plain) begin
					if (is_narrow_mode(seg_mode)) begin
						add_event(KIND_CHAR, {seg_mode, b}, str_idx);
					end else if (seg_mode == MODE_WIDE) begin
						// big-endian pairs; an odd trailing byte never pairs up
						if (!pair_half) begin
							hi_hold = b;
							pair_half = 1'b1;
						end else begin
							add_event(KIND_CHAR, {hi_hold, b}, str_idx);
							pair_half = 1'b0;
						end
					end
				end
				pay_left = pay_left - 8'd1;
				if (pay_left == 8'h00)
					close_segment();
			end
			default: ;
		endcase
		if (is_last) begin
			if (dec_phase != PH_DONE)
				add_event(KIND_ERROR, 16'h0000, str_idx);
			clear_decoder();
		end
		if (pending_events.size() > n0) begin
			e = pending_events.pop_back();
			e.final_event = 1'b1;
			pending_events.insert(pending_events.size(), e);
		end
	endtask

	task automatic push_byte(input logic [7:0] v, input logic is_last);
		stim_byte_t s;
		s.value = v;
		s.is_last = is_last;
		byte_queue.insert(byte_queue.size(), s);
	endtask

	// one structure: mostly well formed, some cut short, a few pure noise
	task automatic add_structure();
		logic [7:0] body[$];
		logic [7:0] mode;
		int shape, nstr, nseg, len, cut, pad, pick;
		shape = $urandom_range(99);
		if (shape < 8) begin
			len = $urandom_range(1, 12);
			for (int i = 0; i < len; i++)
				push_byte(8'($urandom_range(255)), (i == len - 1) || ($urandom_range(7) == 0));
			return;
		end
		nstr = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 3);
		body.insert(body.size(), 8'(nstr));
		for (int s = 0; s < nstr; s++) begin
			for (int k = 0; k < 3; k++)
				body.insert(body.size(), 8'($urandom_range(255)));
			nseg = $urandom_range(0, 3);
			body.insert(body.size(), 8'(nseg));
			for (int g = 0; g < nseg; g++) begin
				body.insert(body.size(),
				            ($urandom_range(4) == 0) ? 8'($urandom_range(1, 255)) : 8'h00);
				pick = $urandom_range(9);
				if (pick < 5) begin
					do
						mode = 8'($urandom_range(8'h33));
					while (!is_narrow_mode(mode));
				end else if (pick < 8) begin
					mode = MODE_WIDE;
				end else begin
					mode = 8'($urandom_range(255));
				end
				body.insert(body.size(), mode);
				len = ($urandom_range(9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 5);
				body.insert(body.size(), 8'(len));
				for (int p = 0; p < len; p++)
					body.insert(body.size(), 8'($urandom_range(255)));
			end
		end
		if (shape < 25 && body.size() > 1) begin
			cut = $urandom_range(1, body.size() - 1);
			for (int i = 0; i < cut; i++)
				push_byte(body[i], i == cut - 1);
		end else begin
			pad = ($urandom_range(2) == 0) ? $urandom_range(1, 3) : 0;
			for (int i = 0; i < body.size(); i++)
				push_byte(body[i], (pad == 0) && (i == body.size() - 1));
			// trailing bytes after completion are ignored up to the last one
			for (int i = 0; i < pad; i++)
				push_byte(8'($urandom_range(255)), i == pad - 1);
		end
	endtask

	function automatic int idle_pct(input bit sender);
		if (bytes_taken * 3 < total_bytes)
			return sender ? 28 : 52;
		if (bytes_taken * 3 < total_bytes * 2)
			return sender ? 52 : 28;
		return 0;
	endfunction

	// request side: note each byte taken and predict its events
	always @(posedge clk) begin
		if (arst_n && byte_valid && !byte_stall) begin
			decode_byte(byte_value, last_byte);
			bytes_taken++;
			req_taken = 1'b1;
		end
	end

	always @(negedge clk) begin
		// hold the request until it is taken
		if (arst_n && (req_taken || !byte_valid)) begin
			req_taken = 1'b0;
			if (byte_queue.size() > 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
				next_req = byte_queue.pop_front();
				byte_valid <= 1'b1;
				byte_value <= next_req.value;
				last_byte <= next_req.is_last;
			end else begin
				byte_valid <= 1'b0;
			end
		end
		event_stall <= ($urandom_range(99) < idle_pct(1'b0));
	end

	always @(posedge clk) begin
		if (arst_n && event_valid && !event_stall) begin
			if (pending_events.size() == 0) begin
				$error("unexpected event: kind %0d char_value %0h string_number %0d",
				       kind, char_value, string_number);
				error_count++;
			end else begin
				want = pending_events.pop_front();
				if (kind !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, kind);
					error_count++;
				end
				if (char_value !== want.char_value) begin
					$error("char_value: expected %0h, got %0h", want.char_value, char_value);
					error_count++;
				end
				if (string_number !== want.string_number) begin
					$error("string_number: expected %0d, got %0d",
					       want.string_number, string_number);
					error_count++;
				end
				if (final_event !== want.final_event) begin
					$error("final_event: expected %0b, got %0b", want.final_event, final_event);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		clear_decoder();
		// empty structure: the count alone completes it
		push_byte(8'h00, 1'b1);
		// one string, narrow segment then a wide segment with an odd byte left over,
		// then bytes ignored after completion
		push_byte(8'h01, 1'b0);
		push_byte(8'h45, 1'b0);
		push_byte(8'h4E, 1'b0);
		push_byte(8'h47, 1'b0);
		push_byte(8'h02, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h02, 1'b0);
		push_byte(8'h41, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(MODE_WIDE, 1'b0);
		push_byte(8'h03, 1'b0);
		push_byte(8'h12, 1'b0);
		push_byte(8'h34, 1'b0);
		push_byte(8'h56, 1'b0);
		push_byte(8'hAA, 1'b0);
		push_byte(8'h55, 1'b1);
		// cut short inside the language code
		push_byte(8'hFF, 1'b0);
		push_byte(8'h61, 1'b1);
		// no segments, and the completing byte is also the last one
		push_byte(8'h01, 1'b0);
		push_byte(8'h78, 1'b0);
		push_byte(8'h79, 1'b0);
		push_byte(8'h7A, 1'b0);
		push_byte(8'h00, 1'b1);
		total_bytes = byte_queue.size() + RANDOM_BYTES;
		while (byte_queue.size() < total_bytes)
			add_structure();
		total_bytes = byte_queue.size();

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (byte_queue.size() != 0 || byte_valid || pending_events.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> sim.f
src/mssd_pkg.sv
src/mssd_decode.sv
src/mssd_event_fifo.sv
src/multiple_string_structure_decoder_core.sv
src/mssd_checker.sv
tb/multiple_string_structure_decoder_core_tb.sv
